@@ src/abllr_pkg.sv @@
// Shared types and constants of the antialiased bilinear line resampler.
`timescale 1ns / 1ps
package abllr_pkg;

    localparam int MAX_LINE_DEF = 2048;
    localparam int COEFF_BITS   = 22;
    localparam int LEN_W        = 12;
    localparam int PIX_W        = 8;
    localparam int NUM_CH       = 3;
    localparam int RGB_W        = NUM_CH * PIX_W;
    localparam int COEF_W       = COEFF_BITS + 1;
    localparam int ACC_W        = COEFF_BITS + PIX_W + 4;
    localparam int SUM_W        = 2 * LEN_W + 1;
    localparam int DIV_NW       = SUM_W + COEFF_BITS + 1 + 4;
    localparam int DIV_DW       = SUM_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_HI_GO,
        ST_HI_WAIT,
        ST_LO_GO,
        ST_LO_WAIT,
        ST_INIT,
        ST_SUM,
        ST_TAP_GO,
        ST_TAP_WAIT,
        ST_EMIT
    } t_state;

    typedef enum logic {
        CFG_SOURCE_LENGTH = 1'b0,
        CFG_TARGET_LENGTH = 1'b1
    } t_cfg_index;

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_PULL = 1'b1
    } t_action;

endpackage

@@ src/antialiased_bilinear_line_resampler_core.sv @@
// Pull: the serial divider, one bit per cycle over 52 bits, computes the upper and
// lower tap span bounds (the lower one is skipped when it is below zero) and then
// each normalized coefficient of the T taps (T up to min(a, 2*ceil(M/b)+1)).
// An early pull answers without the divider. One item is in work at a time; a
// result waits in the output register while pushes go on.
// Reset: both lengths 1, line restarted; the line store is not cleared.
`timescale 1ns / 1ps
module antialiased_bilinear_line_resampler_core #(
    parameter int MAX_LINE = abllr_pkg::MAX_LINE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [abllr_pkg::RGB_W-1:0]   s_axis_tdata,   // red_in, green_in, blue_in
    input  logic [0:0]                    s_axis_tuser,   // action
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [abllr_pkg::RGB_W-1:0]   m_axis_tdata,   // red_out, green_out, blue_out
    output logic                          m_axis_tlast,
    output logic [0:0]                    m_axis_tuser,   // not_ready
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  abllr_pkg::t_cfg_index         i_cfg_index,
    input  logic [abllr_pkg::LEN_W-1:0]   i_cfg_data
);

    import abllr_pkg::*;

    localparam int IW  = $clog2(MAX_LINE);
    localparam int CW  = 2 * LEN_W + 1;
    localparam int DLW = CW + 2;

    t_state r_state, n_state;

    logic [LEN_W-1:0]      r_src_len, r_tgt_len;
    logic [LEN_W-1:0]      r_count, r_tidx;
    logic [LEN_W-1:0]      r_first, r_end, r_i;
    logic [CW-1:0]         r_c;
    logic signed [DLW-1:0] r_d, r_d0;
    logic [SUM_W-1:0]      r_sum;
    logic                  r_nr;
    logic                  r_out_valid;
    logic [RGB_W-1:0]      r_out_data;
    logic                  r_out_last;
    logic                  r_out_nr;

    logic [LEN_W-1:0]      w_a, w_b, w_m;
    logic [LEN_W:0]        w_2m, w_2b;
    logic [CW:0]           w_cb, w_hi_num, w_lo_num;
    logic                  w_lo_neg;
    logic [DLW-1:0]        w_abs_d;
    logic [LEN_W:0]        w_n;
    logic                  w_in_acc, w_push, w_pull, w_cfg_acc, w_out_free;
    logic                  w_div_start, w_div_done;
    logic [DIV_NW-1:0]     w_dividend, w_quo;
    logic [DIV_DW-1:0]     w_divisor;
    logic [LEN_W-1:0]      w_q_len;
    logic [RGB_W-1:0]      w_rd_data;
    logic [RGB_W-1:0]      w_lane_out;
    logic                  w_lane_clear, w_lane_en;
    logic [COEF_W-1:0]     w_coeff;

    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (32'(v) > MAX_LINE) begin
            r = LEN_W'(MAX_LINE);
        end else begin
            r = v;
        end
        return r;
    endfunction

    always_comb begin
        w_a      = eff_len(r_src_len);
        w_b      = eff_len(r_tgt_len);
        w_m      = (w_a > w_b) ? w_a : w_b;
        w_2m     = {w_m, 1'b0};
        w_2b     = {w_b, 1'b0};
        w_cb     = (CW+1)'(r_c) + (CW+1)'(w_b);
        w_hi_num = w_cb + (CW+1)'(w_2m);
        w_lo_neg = w_cb < (CW+1)'(w_2m);
        w_lo_num = w_cb - (CW+1)'(w_2m);
        w_abs_d  = r_d[DLW-1] ? DLW'(-r_d) : DLW'(r_d);
        w_n      = (w_abs_d < DLW'(w_2m)) ? (LEN_W+1)'(DLW'(w_2m) - w_abs_d) : '0;
        w_q_len  = (w_quo > DIV_NW'(w_a)) ? w_a : w_quo[LEN_W-1:0];
        w_coeff  = (r_sum == '0) ? '0 : w_quo[COEF_W-1:0];
    end

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_push     = w_in_acc && (s_axis_tuser == ACT_PUSH);
    assign w_pull     = w_in_acc && (s_axis_tuser == ACT_PULL);
    assign w_cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    // divider operands
    always_comb begin
        w_div_start = 1'b0;
        w_dividend  = '0;
        w_divisor   = DIV_DW'(w_2b);
        unique case (r_state)
            ST_HI_GO: begin
                w_div_start = 1'b1;
                w_dividend  = DIV_NW'(w_hi_num);
            end
            ST_LO_GO: begin
                w_div_start = 1'b1;
                w_dividend  = DIV_NW'(w_lo_num);
            end
            ST_TAP_GO: begin
                w_div_start = r_i < r_end;
                w_dividend  = (DIV_NW'(w_n) << (COEFF_BITS + 1)) + DIV_NW'(r_sum);
                w_divisor   = {r_sum, 1'b0};
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_pull) begin
                    n_state = (r_count < w_a) ? ST_EMIT : ST_MUL;
                end
            end
            ST_MUL:     n_state = ST_HI_GO;
            ST_HI_GO:   n_state = ST_HI_WAIT;
            ST_HI_WAIT: begin
                if (w_div_done) begin
                    n_state = w_lo_neg ? ST_INIT : ST_LO_GO;
                end
            end
            ST_LO_GO:   n_state = ST_LO_WAIT;
            ST_LO_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT:    n_state = ST_SUM;
            ST_SUM: begin
                if (r_i >= r_end) begin
                    n_state = ST_TAP_GO;
                end
            end
            ST_TAP_GO:  n_state = (r_i < r_end) ? ST_TAP_WAIT : ST_EMIT;
            ST_TAP_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_TAP_GO;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_len   <= LEN_W'(1);
            r_tgt_len   <= LEN_W'(1);
            r_count     <= '0;
            r_tidx      <= '0;
            r_out_valid <= 1'b0;
            r_nr        <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_push && (r_count < w_a)) begin
                r_count <= r_count + LEN_W'(1);
            end
            if (w_pull) begin
                r_nr <= r_count < w_a;
            end
            if ((r_state == ST_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
                if (!r_nr) begin
                    if ((r_tidx + LEN_W'(1)) >= w_b) begin
                        r_tidx  <= '0;
                        r_count <= '0;
                    end else begin
                        r_tidx <= r_tidx + LEN_W'(1);
                    end
                end
            end
            if (w_cfg_acc) begin
                unique case (i_cfg_index)
                    CFG_SOURCE_LENGTH: r_src_len <= i_cfg_data;
                    CFG_TARGET_LENGTH: r_tgt_len <= i_cfg_data;
                endcase
                r_count <= '0;
                r_tidx  <= '0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_MUL: begin
                r_c <= CW'({r_tidx, 1'b1}) * CW'(w_a);
            end
            ST_HI_WAIT: begin
                if (w_div_done) begin
                    r_end <= w_q_len;
                    if (w_lo_neg) begin
                        r_first <= '0;
                    end
                end
            end
            ST_LO_WAIT: begin
                if (w_div_done) begin
                    r_first <= w_q_len;
                end
            end
            ST_INIT: begin
                r_d   <= $signed(DLW'({r_first, 1'b1}) * DLW'(w_b)) - $signed(DLW'(r_c));
                r_d0  <= $signed(DLW'({r_first, 1'b1}) * DLW'(w_b)) - $signed(DLW'(r_c));
                r_i   <= r_first;
                r_sum <= '0;
            end
            ST_SUM: begin
                if (r_i < r_end) begin
                    r_sum <= r_sum + SUM_W'(w_n);
                    r_d   <= r_d + $signed(DLW'(w_2b));
                    r_i   <= r_i + LEN_W'(1);
                end else begin
                    r_d <= r_d0;
                    r_i <= r_first;
                end
            end
            ST_TAP_WAIT: begin
                if (w_div_done) begin
                    r_d <= r_d + $signed(DLW'(w_2b));
                    r_i <= r_i + LEN_W'(1);
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    r_out_nr   <= r_nr;
                    r_out_data <= r_nr ? '0 : w_lane_out;
                    r_out_last <= !r_nr && ((r_tidx + LEN_W'(1)) >= w_b);
                end
            end
            default: begin
            end
        endcase
    end

    assign w_lane_clear = (r_state == ST_SUM) && (r_i >= r_end);
    assign w_lane_en    = (r_state == ST_TAP_WAIT) && w_div_done;

    abllr_ram #(
        .WIDTH (RGB_W),
        .DEPTH (MAX_LINE)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_push && (r_count < w_a)),
        .i_wr_addr (r_count[IW-1:0]),
        .i_wr_data (s_axis_tdata),
        .i_rd_addr (r_i[IW-1:0]),
        .o_rd_data (w_rd_data)
    );

    abllr_div #(
        .NW (DIV_NW),
        .DW (DIV_DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
        abllr_lane u_lane (
            .i_clk    (i_clk),
            .i_clear  (w_lane_clear),
            .i_acc_en (w_lane_en),
            .i_pixel  (w_rd_data[g*PIX_W +: PIX_W]),
            .i_coeff  (w_coeff),
            .o_value  (w_lane_out[g*PIX_W +: PIX_W])
        );
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_nr;

endmodule

@@ src/abllr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module abllr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/abllr_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module abllr_div #(
    parameter int NW = 38,
    parameter int DW = 26
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quotient
);

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_div;
    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;

    always_comb begin
        w_trial = {r_rem, r_quo[NW-1]};
        w_ge    = w_trial >= {1'b0, r_div};
        w_diff  = w_trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_quo <= {r_quo[NW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ src/abllr_lane.sv @@
// One color channel lane: weighted accumulation, rounding and clamping.
`timescale 1ns / 1ps
module abllr_lane (
    input  logic                            i_clk,
    input  logic                            i_clear,
    input  logic                            i_acc_en,
    input  logic [abllr_pkg::PIX_W-1:0]     i_pixel,
    input  logic [abllr_pkg::COEF_W-1:0]    i_coeff,
    output logic [abllr_pkg::PIX_W-1:0]     o_value
);

    import abllr_pkg::*;

    localparam int HI_W = ACC_W - COEFF_BITS;

    logic [ACC_W-1:0] r_acc;
    logic [HI_W-1:0]  w_hi;

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_acc <= ACC_W'(1) << (COEFF_BITS - 1);
        end else if (i_acc_en) begin
            r_acc <= r_acc + ACC_W'(i_pixel) * ACC_W'(i_coeff);
        end
    end

    always_comb begin
        w_hi = r_acc[ACC_W-1:COEFF_BITS];
        if (|w_hi[HI_W-1:PIX_W]) begin
            o_value = '1;
        end else begin
            o_value = w_hi[PIX_W-1:0];
        end
    end

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench of the antialiased bilinear line resampler core.
`timescale 1ns / 1ps
module testbench;
    import abllr_pkg::*;

    localparam int LINE_CAP   = 2048;
    localparam int FRAC_BITS  = 22;
    localparam int CYCLE_CAP  = 4000000;
    localparam int HOLD_LEN   = 3000;
    localparam int ITEM_GOAL  = 1950;

    typedef struct packed {
        t_action     act;
        logic [23:0] px;
    } t_src_item;

    typedef struct packed {
        logic [23:0] px;
        logic        last;
        logic        early;
    } t_pixel_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_index  i_cfg_index;
    logic [11:0] i_cfg_data;

    t_src_item   src_queue[$];
    t_pixel_out  pixel_queue[$];
    logic [23:0] line_mem [LINE_CAP];
    logic [11:0] src_len_reg;
    logic [11:0] dst_len_reg;
    int          fill_count;
    int          out_index;
    int          err_count;
    int          cycle_count;
    int          item_count;
    logic        in_fired;
    logic        calm;
    logic        hold_req;
    logic        hold_done;
    int          hold_left;
    int          tx_gap;
    int          rx_gap;

    antialiased_bilinear_line_resampler_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // red_in, green_in, blue_in
        .s_axis_tuser  (s_axis_tuser),   // action
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // red_out, green_out, blue_out
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),   // not_ready
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic longint clip_len(logic [11:0] v);
        if (v == 0) return 1;
        if (v > LINE_CAP) return LINE_CAP;
        return v;
    endfunction

    function automatic longint tap_weight(longint i, longint o, longint a, longint b,
                                          longint m);
        longint d;
        d = (2 * i + 1) * b - (2 * o + 1) * a;
        if (d < 0) d = -d;
        d = 2 * m - d;
        return (d > 0) ? d : 0;
    endfunction

    function automatic logic [23:0] filter_pixel(longint o);
        longint a, b, m, c, lo, hi, first, stop, s, n, coeff, v;
        longint acc [3];
        logic [23:0] px;
        logic [23:0] res;
        a = clip_len(src_len_reg);
        b = clip_len(dst_len_reg);
        m = (a > b) ? a : b;
        c = (2 * o + 1) * a;
        lo = c - 2 * m + b;
        hi = (c + 2 * m + b) / (2 * b);
        first = (lo < 0) ? 0 : lo / (2 * b);
        stop = (hi < a) ? hi : a;
        s = 0;
        for (longint i = first; i < stop; i++) s += tap_weight(i, o, a, b, m);
        for (int ch = 0; ch < 3; ch++) acc[ch] = longint'(1) << (FRAC_BITS - 1);
        for (longint i = first; i < stop; i++) begin
            n = tap_weight(i, o, a, b, m);
            coeff = (s > 0) ? ((n << (FRAC_BITS + 1)) + s) / (2 * s) : 0;
            px = line_mem[i];
            for (int ch = 0; ch < 3; ch++) acc[ch] += longint'(px[8*ch +: 8]) * coeff;
        end
        for (int ch = 0; ch < 3; ch++) begin
            v = acc[ch] >>> FRAC_BITS;
            res[8*ch +: 8] = (v > 255) ? 8'hFF : v[7:0];
        end
        return res;
    endfunction

    task automatic predict_item(t_src_item it);
        t_pixel_out r;
        longint a, b;
        a = clip_len(src_len_reg);
        b = clip_len(dst_len_reg);
        if (it.act == ACT_PUSH) begin
            if (fill_count < a) begin
                line_mem[fill_count] = it.px;
                fill_count++;
            end
        end else if (fill_count < a) begin
            r = '{px: 24'h0, last: 1'b0, early: 1'b1};
            pixel_queue.push_back(r);
        end else begin
            r.px = filter_pixel(out_index);
            r.early = 1'b0;
            if (out_index + 1 >= b) begin
                r.last = 1'b1;
                out_index = 0;
                fill_count = 0;
            end else begin
                r.last = 1'b0;
                out_index++;
            end
            pixel_queue.push_back(r);
        end
    endtask

    task automatic report(string what, logic [23:0] got, logic [23:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_pixel_out w;
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("TEST FAILED");
            $finish;
        end
        if (m_axis_tvalid && m_axis_tready) begin
            if (pixel_queue.size() == 0) begin
                report("unexpected transfer", m_axis_tdata, 24'h0);
            end else begin
                w = pixel_queue.pop_front();
                if (m_axis_tdata !== w.px) report("pixel", m_axis_tdata, w.px);
                if (m_axis_tlast !== w.last) report("tlast", m_axis_tlast, w.last);
                if (m_axis_tuser[0] !== w.early) report("tuser", m_axis_tuser, w.early);
            end
        end
        if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_SOURCE_LENGTH) src_len_reg = i_cfg_data;
            else dst_len_reg = i_cfg_data;
            fill_count = 0;
            out_index = 0;
        end
        in_fired <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready) predict_item(src_queue.pop_front());
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_fired) begin
            s_axis_tvalid <= 1'b1;
        end else if (tx_gap > 0) begin
            tx_gap <= tx_gap - 1;
            s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            tx_gap <= $urandom_range(0, 18);
            s_axis_tvalid <= 1'b0;
        end else if (src_queue.size() > 0) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= src_queue[0].px;
            s_axis_tuser <= src_queue[0].act;
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            rx_gap <= $urandom_range(0, 18);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic add_push(logic [23:0] px);
        src_queue.push_back('{act: ACT_PUSH, px: px});
        item_count++;
    endtask

    task automatic add_pull();
        src_queue.push_back('{act: ACT_PULL, px: 24'($urandom)});
        item_count++;
    endtask

    task automatic drain();
        while (src_queue.size() > 0 || pixel_queue.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [11:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_lengths(logic [11:0] a, logic [11:0] b);
        drain();
        write_reg(CFG_SOURCE_LENGTH, a);
        write_reg(CFG_TARGET_LENGTH, b);
    endtask

    task automatic add_line(int a, int b, bit noisy);
        for (int k = 0; k < a; k++) begin
            if (noisy && $urandom_range(0, 15) == 0) add_pull();
            add_push(24'($urandom));
        end
        if (noisy && $urandom_range(0, 3) == 0) add_push(24'($urandom));
        for (int k = 0; k < b; k++) add_pull();
    endtask

    initial begin
        int a, b, cut;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SOURCE_LENGTH;
        i_cfg_data = '0;
        src_len_reg = 12'd1;
        dst_len_reg = 12'd1;
        fill_count = 0;
        out_index = 0;
        err_count = 0;
        cycle_count = 0;
        item_count = 0;
        in_fired = 1'b0;
        calm = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        tx_gap = 0;
        rx_gap = 0;
        for (int k = 0; k < LINE_CAP; k++) line_mem[k] = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_pull();
        add_push(24'h000000);
        add_push(24'h123456);
        add_pull();
        add_push(24'hFFFFFF);
        add_pull();
        set_lengths(12'd3, 12'd2);
        add_push(24'hFF00FF);
        add_pull();
        add_push(24'h00FF00);
        add_push(24'hFFFFFF);
        add_pull();
        add_pull();
        set_lengths(12'd2, 12'd5);
        add_line(2, 5, 1'b0);
        set_lengths(12'd0, 12'd4095);
        add_push(24'hA5C3E1);
        for (int k = 0; k < 40; k++) add_pull();
        set_lengths(12'd4095, 12'd0);
        for (int k = 0; k < 40; k++) add_push(24'($urandom));
        add_pull();

        while (item_count < ITEM_GOAL) begin
            if ($urandom_range(0, 19) == 0) begin
                a = $urandom_range(1, 64);
                b = $urandom_range(1, 64);
            end else begin
                a = $urandom_range(1, 12);
                b = $urandom_range(1, 12);
            end
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1)) a = 0;
                else b = 0;
            end
            set_lengths(12'(a), 12'(b));
            if (a == 0) a = 1;
            if (b == 0) b = 1;
            if (!hold_req && item_count > ITEM_GOAL / 3) begin
                hold_req = 1'b1;
                for (int k = 0; k < 8; k++) add_line(a, b, 1'b0);
            end
            for (int n = $urandom_range(1, 3); n > 0; n--) begin
                if ($urandom_range(0, 7) == 0) begin
                    cut = $urandom_range(0, a);
                    for (int k = 0; k < cut; k++) add_push(24'($urandom));
                    add_pull();
                end else begin
                    add_line(a, b, 1'b1);
                end
            end
            if (item_count > ITEM_GOAL - 150) calm = 1'b1;
        end
        drain();
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
